### design/sprs_pkg.sv
// sprs_pkg: shared widths, command and status codes for the slotted page store.
// No dependencies; imported by every module of the design.
package sprs_pkg;

    localparam int CMD_W  = 3;
    localparam int SLOT_W = 9;
    localparam int LEN_W  = 13;
    localparam int POS_W  = 12;
    localparam int DATA_W = 8;
    localparam int ST_W   = 2;
    localparam int FS_W   = 13;

    localparam int FS_MAX = (1 << FS_W) - 1;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [ST_W-1:0]   t_status;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [FS_W-1:0]   t_free;

    localparam t_cmd CMD_INS_BEGIN = 3'd0;
    localparam t_cmd CMD_INS_BYTE  = 3'd1;
    localparam t_cmd CMD_RD_INFO   = 3'd2;
    localparam t_cmd CMD_RD_BYTE   = 3'd3;
    localparam t_cmd CMD_DELETE    = 3'd4;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_SPACE = 2'd1;
    localparam t_status ST_BAD_SLOT = 2'd2;
    localparam t_status ST_BAD_POS  = 2'd3;

endpackage

### design/slotted_page_record_store_core.sv
// slotted_page_record_store_core: slotted page record store, top level.
// Uses sprs_pkg, sprs_slot_dir and sprs_byte_store.
//
//   port group        dir  handshake          word
//   ----------------  ---  -----------------  ---------------------------------
//   command           in   start && !busy     i_cmd .. i_data_byte_in
//   result            out  o_valid strobe     o_status .. o_dirty_flag
//
// One word accepted per cycle while busy is low. The input register and slot directory
// read come first, then the result register and byte store read. Synchronous reset
// starts a zero-fill of every byte of the byte store, with busy held high.
// The result side cannot stall: o_valid is high for exactly one cycle per word.
module slotted_page_record_store_core #(
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 12,
    parameter int SLOT_BYTES   = 8,
    parameter int MAX_SLOTS    = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sprs_pkg::t_cmd    i_cmd,
    input  sprs_pkg::t_slot   i_slot_index,
    input  sprs_pkg::t_len    i_record_length,
    input  sprs_pkg::t_pos    i_byte_position,
    input  sprs_pkg::t_data   i_data_byte_in,
    output logic              o_valid,
    output sprs_pkg::t_status o_status,
    output sprs_pkg::t_slot   o_slot_out,
    output sprs_pkg::t_len    o_length_out,
    output sprs_pkg::t_data   o_data_byte_out,
    output sprs_pkg::t_free   o_free_space,
    output logic              o_dirty_flag
);
    import sprs_pkg::*;

    localparam int AW = $clog2(PAGE_BYTES);
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int RW = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam int LW = $clog2(PAGE_BYTES + (1 << LEN_W) + SLOT_BYTES) + 2;

    // free offset starts below the header, and the space check counts the header again
    localparam logic signed [LW-1:0] SLOT_S    = LW'(SLOT_BYTES);
    localparam logic signed [LW-1:0] LEFT_INIT =
        LW'(PAGE_BYTES - 2 * HEADER_BYTES - SLOT_BYTES);
    localparam logic signed [LW-1:0] FS_MAX_S  = LW'(FS_MAX);
    localparam logic [AW-1:0]        FREE_INIT = AW'(PAGE_BYTES - HEADER_BYTES);

    logic accept;

    // stage 1: registered command
    logic  r1_vld;
    t_cmd  r1_cmd;
    t_slot r1_idx;
    t_len  r1_len;
    t_pos  r1_pos;
    t_data r1_din;

    // page state
    logic [CW-1:0]          r_slot_count, n_slot_count;
    logic [AW-1:0]          r_free_off,   n_free_off;
    logic signed [LW-1:0]   r_left,       n_left;
    logic [AW-1:0]          r_wp,         n_wp;
    t_len                   r_pending,    n_pending;
    logic                   r_modified,   n_modified;

    // stage 2: result register
    logic    r2_vld;
    t_status r2_status;
    t_slot   r2_slot;
    t_len    r2_len;
    logic    r2_rd;
    t_free   r2_free;
    logic    r2_dirty;

    // slot directory
    logic          dir_live;
    logic [AW-1:0] dir_off;
    t_len          dir_len;
    logic          dir_we;
    logic          dir_kill;
    logic [SW-1:0] dir_waddr;

    // byte store
    logic          clearing;
    logic          byte_we;
    logic [AW-1:0] byte_raddr;
    t_data         byte_rdata;

    // stage 1 datapath
    logic signed [LW-1:0] len_s;
    logic signed [LW-1:0] ins_left;
    logic signed [LW-1:0] free_diff;
    logic                 dir_room;
    logic                 ins_short;
    logic                 slot_ok;
    logic [RW-1:0]        rb_sum;
    t_status              st;
    t_slot                slot_o;
    t_len                 len_o;
    logic                 rd;
    t_free                fs;

    assign busy   = clearing;
    assign accept = start && !busy;

    sprs_slot_dir #(
        .MAX_SLOTS (MAX_SLOTS),
        .OFF_W     (AW)
    ) u_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (SW'(i_slot_index)),
        .o_live  (dir_live),
        .o_off   (dir_off),
        .o_len   (dir_len),
        .i_we    (dir_we),
        .i_kill  (dir_kill),
        .i_waddr (dir_waddr),
        .i_woff  (n_free_off),
        .i_wlen  (r1_len)
    );

    sprs_byte_store #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_bytes (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (clearing),
        .i_we       (byte_we),
        .i_waddr    (r_wp),
        .i_wdata    (r1_din),
        .i_raddr    (byte_raddr),
        .o_rdata    (byte_rdata)
    );

    always_ff @(posedge i_clk) begin
        r1_cmd <= i_cmd;
        r1_idx <= i_slot_index;
        r1_len <= i_record_length;
        r1_pos <= i_byte_position;
        r1_din <= i_data_byte_in;
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
    end

    assign len_s     = $signed(LW'(r1_len));
    assign free_diff = $signed(LW'(r_free_off)) - len_s;
    assign ins_left  = r_left - len_s - SLOT_S;
    assign dir_room  = r_slot_count < CW'(MAX_SLOTS);
    assign ins_short = r_left < len_s;
    assign slot_ok   = (r1_idx < r_slot_count) && dir_live;
    assign rb_sum    = RW'(dir_off) + RW'(r1_pos);
    assign byte_raddr = rb_sum[AW-1:0];
    assign dir_waddr = (r1_cmd == CMD_INS_BEGIN) ? SW'(r_slot_count) : SW'(r1_idx);

    always_comb begin
        n_slot_count = r_slot_count;
        n_free_off   = free_diff[AW-1:0];
        n_left       = r_left;
        n_wp         = r_wp;
        n_pending    = r_pending;
        n_modified   = r_modified;
        st           = ST_OK;
        slot_o       = '0;
        len_o        = '0;
        rd           = 1'b0;
        dir_we       = 1'b0;
        dir_kill     = 1'b0;
        byte_we      = 1'b0;
        if (r1_vld) begin
            case (r1_cmd)
                CMD_INS_BEGIN: begin
                    if (!dir_room || ins_short) begin
                        st = ST_NO_SPACE;
                    end else begin
                        n_left       = ins_left;
                        n_slot_count = r_slot_count + CW'(1);
                        slot_o       = SLOT_W'(r_slot_count);
                        n_wp         = free_diff[AW-1:0];
                        n_pending    = r1_len;
                        n_modified   = 1'b1;
                        dir_we       = 1'b1;
                    end
                end
                CMD_INS_BYTE: begin
                    if (r_pending == '0) begin
                        st = ST_BAD_POS;
                    end else begin
                        byte_we    = 1'b1;
                        n_wp       = r_wp + AW'(1);
                        n_pending  = r_pending - LEN_W'(1);
                        n_modified = 1'b1;
                    end
                end
                CMD_RD_INFO: begin
                    if (!slot_ok) begin
                        st = ST_BAD_SLOT;
                    end else begin
                        len_o = dir_len;
                    end
                end
                CMD_RD_BYTE: begin
                    if (!slot_ok) begin
                        st = ST_BAD_SLOT;
                    end else if (r1_pos >= dir_len) begin
                        st = ST_BAD_POS;
                    end else begin
                        rd = rb_sum < RW'(PAGE_BYTES);
                    end
                end
                CMD_DELETE: begin
                    if (!slot_ok) begin
                        st = ST_BAD_SLOT;
                    end else begin
                        dir_kill   = 1'b1;
                        n_modified = 1'b1;
                    end
                end
                default: begin
                    st = ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        if (n_left < 0) begin
            fs = '0;
        end else if (n_left > FS_MAX_S) begin
            fs = FS_W'(FS_MAX);
        end else begin
            fs = n_left[FS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r2_status <= st;
        r2_slot   <= slot_o;
        r2_len    <= len_o;
        r2_rd     <= rd;
        r2_free   <= fs;
        r2_dirty  <= n_modified;
        if (!i_rst_n) begin
            r2_vld       <= 1'b0;
            r_slot_count <= '0;
            r_free_off   <= FREE_INIT;
            r_left       <= LEFT_INIT;
            r_wp         <= '0;
            r_pending    <= '0;
            r_modified   <= 1'b0;
        end else begin
            r2_vld       <= r1_vld;
            r_slot_count <= n_slot_count;
            r_free_off   <= dir_we ? n_free_off : r_free_off;
            r_left       <= n_left;
            r_wp         <= n_wp;
            r_pending    <= n_pending;
            r_modified   <= n_modified;
        end
    end

    assign o_valid         = r2_vld;
    assign o_status        = r2_status;
    assign o_slot_out      = r2_slot;
    assign o_length_out    = r2_len;
    assign o_data_byte_out = r2_rd ? byte_rdata : '0;
    assign o_free_space    = r2_free;
    assign o_dirty_flag    = r2_dirty;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted word produced no result");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (!r1_vld && !r2_vld))
        else $error("word in flight during byte store clear");

    a_dirty_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_modified))
        else $error("dirty flag dropped without reset");

    a_nospace_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NO_SPACE) |-> (o_slot_out == '0))
        else $error("failed insert reported a slot");
`endif

endmodule

### design/sprs_slot_dir.sv
// sprs_slot_dir: slot directory memories (offset, length, live) with registered read.
// Forwards the write of the previous edge to a read issued at that same edge.
// Depends on sprs_pkg.
module sprs_slot_dir #(
    parameter int MAX_SLOTS = 512,
    parameter int OFF_W     = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [$clog2(MAX_SLOTS)-1:0] i_raddr,
    output logic                         o_live,
    output logic [OFF_W-1:0]             o_off,
    output sprs_pkg::t_len               o_len,
    input  logic                         i_we,
    input  logic                         i_kill,
    input  logic [$clog2(MAX_SLOTS)-1:0] i_waddr,
    input  logic [OFF_W-1:0]             i_woff,
    input  sprs_pkg::t_len               i_wlen
);
    import sprs_pkg::*;

    localparam int SW = $clog2(MAX_SLOTS);

    logic [OFF_W-1:0] mem_off  [MAX_SLOTS];
    t_len             mem_len  [MAX_SLOTS];
    logic             mem_live [MAX_SLOTS];

    logic [OFF_W-1:0] r_q_off;
    t_len             r_q_len;
    logic             r_q_live;
    logic [SW-1:0]    r_raddr;

    logic             r_byp_vld;
    logic             r_byp_ol;
    logic [SW-1:0]    r_byp_addr;
    logic [OFF_W-1:0] r_byp_off;
    t_len             r_byp_len;
    logic             r_byp_live;

    logic             hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_off[i_waddr] <= i_woff;
            mem_len[i_waddr] <= i_wlen;
        end
        r_q_off <= mem_off[i_raddr];
        r_q_len <= mem_len[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we || i_kill) begin
            mem_live[i_waddr] <= i_we;
        end
        r_q_live <= mem_live[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_raddr    <= i_raddr;
        r_byp_addr <= i_waddr;
        r_byp_off  <= i_woff;
        r_byp_len  <= i_wlen;
        r_byp_live <= i_we;
        if (!i_rst_n) begin
            r_byp_vld <= 1'b0;
            r_byp_ol  <= 1'b0;
        end else begin
            r_byp_vld <= i_we || i_kill;
            r_byp_ol  <= i_we;
        end
    end

    assign hit    = r_byp_vld && (r_byp_addr == r_raddr);
    assign o_live = hit ? r_byp_live : r_q_live;
    assign o_off  = (hit && r_byp_ol) ? r_byp_off : r_q_off;
    assign o_len  = (hit && r_byp_ol) ? r_byp_len : r_q_len;

endmodule

### design/sprs_byte_store.sv
// sprs_byte_store: page byte memory, one write and one registered read per cycle.
// Runs a zero-fill pass over every byte after reset. Depends on sprs_pkg.
module sprs_byte_store #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    output logic                          o_clearing,
    input  logic                          i_we,
    input  logic [$clog2(PAGE_BYTES)-1:0] i_waddr,
    input  sprs_pkg::t_data               i_wdata,
    input  logic [$clog2(PAGE_BYTES)-1:0] i_raddr,
    output sprs_pkg::t_data               o_rdata
);
    import sprs_pkg::*;

    localparam int AW = $clog2(PAGE_BYTES);

    t_data         mem [PAGE_BYTES];
    t_data         r_q;
    logic          r_clr_active;
    logic [AW-1:0] r_clr_addr;

    logic          we;
    logic [AW-1:0] waddr;
    t_data         wdata;

    assign we    = r_clr_active || i_we;
    assign waddr = r_clr_active ? r_clr_addr : i_waddr;
    assign wdata = r_clr_active ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_q <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == AW'(PAGE_BYTES - 1)) begin
                r_clr_active <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_clearing = r_clr_active;
    assign o_rdata    = r_q;

endmodule

### test/testbench.sv
// testbench: self-checking bench for slotted_page_record_store_core.
// Drives command words from a queue, predicts every result word from its own
// page model and checks each strobed result; imports only sprs_pkg.
module testbench;
    import sprs_pkg::*;

    localparam int PAGE_SZ      = 4096;
    localparam int HDR_SZ       = 12;
    localparam int SLOT_SZ      = 8;
    localparam int MAX_SL       = 512;
    localparam int RAND_TARGET  = 480;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam t_cmd CMD_TOP    = '1;

    typedef struct packed {
        t_cmd  cmd;
        t_slot slot;
        t_len  len;
        t_pos  pos;
        t_data data;
    } page_cmd_t;

    typedef struct packed {
        t_status status;
        t_slot   slot;
        t_len    length;
        t_data   data;
        t_free   free;
        logic    dirty;
    } page_reply_t;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_cmd    i_cmd = '0;
    t_slot   i_slot_index = '0;
    t_len    i_record_length = '0;
    t_pos    i_byte_position = '0;
    t_data   i_data_byte_in = '0;
    logic    o_valid;
    t_status o_status;
    t_slot   o_slot_out;
    t_len    o_length_out;
    t_data   o_data_byte_out;
    t_free   o_free_space;
    logic    o_dirty_flag;

    slotted_page_record_store_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cmd(i_cmd),
        .i_slot_index(i_slot_index),
        .i_record_length(i_record_length),
        .i_byte_position(i_byte_position),
        .i_data_byte_in(i_data_byte_in),
        .o_valid(o_valid),
        .o_status(o_status),
        .o_slot_out(o_slot_out),
        .o_length_out(o_length_out),
        .o_data_byte_out(o_data_byte_out),
        .o_free_space(o_free_space),
        .o_dirty_flag(o_dirty_flag)
    );

    // page shadow
    bit [7:0]  page_mem [PAGE_SZ];
    bit [11:0] rec_off  [MAX_SL];
    bit [12:0] rec_len  [MAX_SL];
    bit        rec_live [MAX_SL];
    int        n_slots = 0;
    int        free_off = PAGE_SZ - HDR_SZ;
    int        wr_ptr = 0;
    int        bytes_owed = 0;
    bit        dirty = 1'b0;

    page_cmd_t   pending_cmds[$];
    page_reply_t due_replies[$];
    int          errors = 0;
    int          n_items = 0;
    int          gap_chance = 20;
    int          gap_left = 0;
    bit          just_taken = 1'b0;
    int          cycle_cnt = 0;

    function automatic page_reply_t page_apply(page_cmd_t c);
        page_reply_t r;
        int len_v, need, left, addr;
        r = '0;
        r.status = ST_OK;
        len_v = int'(c.len);
        need = HDR_SZ + (n_slots + 1) * SLOT_SZ;
        case (c.cmd)
            CMD_INS_BEGIN: begin
                if (n_slots >= MAX_SL || free_off - len_v < need) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    free_off -= len_v;
                    rec_off[n_slots] = 12'(free_off);
                    rec_len[n_slots] = c.len;
                    rec_live[n_slots] = 1'b1;
                    r.slot = SLOT_W'(n_slots);
                    n_slots++;
                    wr_ptr = free_off;
                    bytes_owed = len_v;
                    dirty = 1'b1;
                end
            end
            CMD_INS_BYTE: begin
                if (bytes_owed == 0) begin
                    r.status = ST_BAD_POS;
                end else begin
                    if (wr_ptr < PAGE_SZ) page_mem[wr_ptr] = c.data;
                    wr_ptr++;
                    bytes_owed--;
                    dirty = 1'b1;
                end
            end
            CMD_RD_INFO: begin
                if (!(c.slot < n_slots && rec_live[c.slot])) r.status = ST_BAD_SLOT;
                else r.length = rec_len[c.slot];
            end
            CMD_RD_BYTE: begin
                if (!(c.slot < n_slots && rec_live[c.slot])) begin
                    r.status = ST_BAD_SLOT;
                end else if (c.pos >= rec_len[c.slot]) begin
                    r.status = ST_BAD_POS;
                end else begin
                    addr = int'(rec_off[c.slot]) + int'(c.pos);
                    if (addr < PAGE_SZ) r.data = page_mem[addr];
                end
            end
            CMD_DELETE: begin
                if (!(c.slot < n_slots && rec_live[c.slot])) begin
                    r.status = ST_BAD_SLOT;
                end else begin
                    rec_live[c.slot] = 1'b0;
                    dirty = 1'b1;
                end
            end
            default: ;
        endcase
        left = free_off - (HDR_SZ + (n_slots + 1) * SLOT_SZ);
        r.free = FS_W'((left < 0) ? 0 : ((left > FS_MAX) ? FS_MAX : left));
        r.dirty = dirty;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    function automatic page_cmd_t any_cmd();
        page_cmd_t c;
        c.cmd  = CMD_W'($urandom_range(0, CMD_TOP));
        c.slot = SLOT_W'($urandom_range(0, MAX_SL - 1));
        c.len  = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
        c.pos  = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        c.data = DATA_W'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic page_cmd_t mk(t_cmd op, int slot, int len, int pos, int data);
        page_cmd_t c;
        c.cmd  = op;
        c.slot = SLOT_W'(slot);
        c.len  = LEN_W'(len);
        c.pos  = POS_W'(pos);
        c.data = DATA_W'(data);
        return c;
    endfunction

    // mostly a slot that exists, sometimes any index
    function automatic int pick_slot();
        if (n_slots > 0 && $urandom_range(0, 7) != 0) return int'($urandom_range(0, n_slots - 1));
        return int'($urandom_range(0, MAX_SL - 1));
    endfunction

    task automatic queue_cmd(page_cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
        n_items++;
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // driver: one word per handshake, random idle bursts after accepted words
    always @(negedge i_clk) begin : driver
        page_cmd_t c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (just_taken && gap_chance > 0 && $urandom_range(1, 100) <= gap_chance)
                gap_left = $urandom_range(1, 13);
            just_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds[0];
                i_cmd           <= c.cmd;
                i_slot_index    <= c.slot;
                i_record_length <= c.len;
                i_byte_position <= c.pos;
                i_data_byte_in  <= c.data;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check strobed results, predict accepted words
    always @(posedge i_clk) begin : monitor
        page_reply_t want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (due_replies.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    want = due_replies.pop_front();
                    check_field("status", 16'(want.status), 16'(o_status));
                    check_field("slot_out", 16'(want.slot), 16'(o_slot_out));
                    check_field("length_out", 16'(want.length), 16'(o_length_out));
                    check_field("data_byte_out", 16'(want.data), 16'(o_data_byte_out));
                    check_field("free_space", 16'(want.free), 16'(o_free_space));
                    check_field("dirty_flag", 16'(want.dirty), 16'(o_dirty_flag));
                end
            end
            if (start && !busy && pending_cmds.size() > 0) begin
                due_replies.insert(due_replies.size(), page_apply(pending_cmds.pop_front()));
                just_taken = 1'b1;
            end
        end
    end

    initial begin
        page_cmd_t c;
        int pick, len, nb, s, fit, big_slot, next_mood;

        // directed: empty page, bad slots, no open insert, unknown ops, oversized inserts
        queue_cmd(mk(CMD_RD_INFO, 0, 0, 0, 0));
        queue_cmd(mk(CMD_INS_BYTE, 0, 0, 0, 8'hFF));
        queue_cmd(mk(CMD_DELETE, MAX_SL - 1, 0, 0, 0));
        queue_cmd(mk(t_cmd'(CMD_DELETE + 1), MAX_SL - 1, (1 << LEN_W) - 1,
                     (1 << POS_W) - 1, 8'hFF));
        queue_cmd(mk(CMD_TOP, 0, 0, 0, 0));
        queue_cmd(mk(CMD_INS_BEGIN, 0, (1 << LEN_W) - 1, 0, 0));
        queue_cmd(mk(CMD_INS_BEGIN, 0, PAGE_SZ, 0, 0));
        // zero-length record
        queue_cmd(mk(CMD_INS_BEGIN, 0, 0, 0, 0));
        queue_cmd(mk(CMD_RD_INFO, 0, 0, 0, 0));
        queue_cmd(mk(CMD_RD_BYTE, 0, 0, 0, 0));
        // three-byte record, one byte too many
        queue_cmd(mk(CMD_INS_BEGIN, 0, 3, 0, 0));
        queue_cmd(mk(CMD_INS_BYTE, 0, 0, 0, 8'hFF));
        queue_cmd(mk(CMD_INS_BYTE, 0, 0, 0, 8'h00));
        queue_cmd(mk(CMD_INS_BYTE, 0, 0, 0, 8'hA5));
        queue_cmd(mk(CMD_INS_BYTE, 0, 0, 0, 8'h5A));
        queue_cmd(mk(CMD_RD_BYTE, 1, 0, 2, 0));
        queue_cmd(mk(CMD_RD_BYTE, 1, 0, (1 << POS_W) - 1, 0));
        // insert replaced while still open
        queue_cmd(mk(CMD_INS_BEGIN, 0, 4, 0, 0));
        queue_cmd(mk(CMD_INS_BYTE, 0, 0, 0, 8'h11));
        queue_cmd(mk(CMD_INS_BYTE, 0, 0, 0, 8'h22));
        queue_cmd(mk(CMD_INS_BEGIN, 0, 2, 0, 0));
        queue_cmd(mk(CMD_INS_BYTE, 0, 0, 0, 8'h3C));
        queue_cmd(mk(CMD_RD_BYTE, 2, 0, 3, 0));
        queue_cmd(mk(CMD_DELETE, 1, 0, 0, 0));
        queue_cmd(mk(CMD_DELETE, 1, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        next_mood = 0;
        while (n_items < RAND_TARGET) begin
            while (pending_cmds.size() > 2) @(posedge i_clk);
            if (n_items >= next_mood) begin
                gap_chance = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                next_mood += 40;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                  : $urandom_range(0, 12);
                nb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len;
                c = any_cmd();
                c.cmd = CMD_INS_BEGIN;
                c.len = LEN_W'(len);
                queue_cmd(c);
                for (int i = 0; i < nb; i++) begin
                    c = any_cmd();
                    c.cmd = CMD_INS_BYTE;
                    queue_cmd(c);
                end
            end else if (pick < 65) begin
                s = pick_slot();
                c = any_cmd();
                c.cmd = CMD_RD_BYTE;
                c.slot = SLOT_W'(s);
                if (s < n_slots && rec_len[s] != 0 && $urandom_range(0, 5) != 0)
                    c.pos = POS_W'($urandom_range(0, rec_len[s] - 1));
                queue_cmd(c);
            end else if (pick < 75) begin
                c = any_cmd();
                c.cmd = CMD_RD_INFO;
                c.slot = SLOT_W'(pick_slot());
                queue_cmd(c);
            end else if (pick < 85) begin
                c = any_cmd();
                c.cmd = CMD_DELETE;
                c.slot = SLOT_W'(pick_slot());
                queue_cmd(c);
            end else begin
                queue_cmd(any_cmd());
            end
        end

        // last part: exact fill of the page, no idling
        gap_chance = 0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        fit = free_off - (HDR_SZ + (n_slots + 1) * SLOT_SZ);
        big_slot = n_slots;
        queue_cmd(mk(CMD_INS_BEGIN, 0, fit + 1, 0, 0));
        if (fit >= 0) begin
            queue_cmd(mk(CMD_INS_BEGIN, 0, fit, 0, 0));
            for (int i = 0; i < 3 && i < fit; i++)
                queue_cmd(mk(CMD_INS_BYTE, 0, 0, 0, int'($urandom_range(0, 255))));
            queue_cmd(mk(CMD_RD_INFO, big_slot, 0, 0, 0));
            queue_cmd(mk(CMD_RD_BYTE, big_slot, 0, 0, 0));
            queue_cmd(mk(CMD_RD_BYTE, big_slot, 0, (fit > 0) ? fit - 1 : 0, 0));
        end
        queue_cmd(mk(CMD_INS_BEGIN, 0, 0, 0, 0));
        queue_cmd(mk(CMD_DELETE, big_slot, 0, 0, 0));
        queue_cmd(mk(CMD_RD_INFO, big_slot, 0, 0, 0));

        while (pending_cmds.size() != 0 || due_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && due_replies.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
